// ----- rtl/sfr_pkg.sv -----
package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_LENGTH_BITS = 16;

    localparam int LANES_W    = MAX_PATTERN * 8;
    localparam int CNT_W      = $clog2(MAX_PATTERN + 1);
    localparam int LEN_REG_W  = 4;
    localparam int BUF_W      = 16;
    localparam int TOTAL_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [CFG_DATA_W-1:0] RST_SEARCH_PATTERN  = {48'h0, CHAR_LF, CHAR_CR};
    localparam logic [LEN_REG_W-1:0]  RST_SEARCH_LENGTH   = 4'd2;
    localparam logic [CFG_DATA_W-1:0] RST_REPLACE_PATTERN = {56'h0, CHAR_SPACE};
    localparam logic [LEN_REG_W-1:0]  RST_REPLACE_LENGTH  = 4'd1;
    localparam logic [BUF_W-1:0]      RST_BUFFER_LENGTH   = 16'hffff;

    localparam logic [TOTAL_W-1:0] COUNT_SAT = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEARCH_PATTERN  = 3'd0,
        REG_SEARCH_LENGTH   = 3'd1,
        REG_REPLACE_PATTERN = 3'd2,
        REG_REPLACE_LENGTH  = 3'd3,
        REG_BUFFER_LENGTH   = 3'd4
    } t_cfg_reg;

    // effective configuration, lengths already clamped
    typedef struct packed {
        logic [LANES_W-1:0] search_pattern;
        logic [CNT_W-1:0]   search_len;
        logic [LANES_W-1:0] replace_pattern;
        logic [CNT_W-1:0]   replace_len;
        logic [BUF_W-1:0]   buffer_length;
    } t_cfg;

    // results of one item: flushed bytes, then new bytes, then optional end marker
    typedef struct packed {
        logic [LANES_W-1:0] a_bytes;
        logic [CNT_W-1:0]   a_cnt;
        logic [LANES_W-1:0] b_bytes;
        logic [CNT_W-1:0]   b_cnt;
        logic               mark;
        logic [TOTAL_W-1:0] total;
    } t_burst;

endpackage

// ----- rtl/sfr_in_if.sv -----
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ----- rtl/sfr_out_if.sv -----
interface sfr_out_if;
    logic                         valid;
    logic                         ready;
    logic [7:0]                   out_byte;
    logic                         byte_valid;
    logic                         last;
    logic [sfr_pkg::TOTAL_W-1:0]  replace_count;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output replace_count, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last,
                    input replace_count, output ready);
endinterface

// ----- rtl/sfr_cfg.sv -----
module sfr_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output sfr_pkg::t_cfg                    o_cfg
);

    localparam int NP = sfr_pkg::MAX_PATTERN;
    localparam int CW = sfr_pkg::CNT_W;
    localparam int PW = sfr_pkg::LANES_W;
    localparam int LRW = sfr_pkg::LEN_REG_W;

    logic [sfr_pkg::CFG_DATA_W-1:0] r_search_pattern;
    logic [LRW-1:0]                 r_search_len;
    logic [sfr_pkg::CFG_DATA_W-1:0] r_replace_pattern;
    logic [LRW-1:0]                 r_replace_len;
    logic [sfr_pkg::BUF_W-1:0]      r_buffer_length;

    logic [LRW-1:0] slen;
    logic [LRW-1:0] rlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_pattern  <= sfr_pkg::RST_SEARCH_PATTERN;
            r_search_len      <= sfr_pkg::RST_SEARCH_LENGTH;
            r_replace_pattern <= sfr_pkg::RST_REPLACE_PATTERN;
            r_replace_len     <= sfr_pkg::RST_REPLACE_LENGTH;
            r_buffer_length   <= sfr_pkg::RST_BUFFER_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sfr_pkg::REG_SEARCH_PATTERN:  r_search_pattern  <= i_cfg_data;
                sfr_pkg::REG_SEARCH_LENGTH:   r_search_len      <= i_cfg_data[LRW-1:0];
                sfr_pkg::REG_REPLACE_PATTERN: r_replace_pattern <= i_cfg_data;
                sfr_pkg::REG_REPLACE_LENGTH:  r_replace_len     <= i_cfg_data[LRW-1:0];
                sfr_pkg::REG_BUFFER_LENGTH:
                    r_buffer_length <= i_cfg_data[sfr_pkg::BUF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        slen = r_search_len;
        if (slen == '0) begin
            slen = LRW'(1);
        end else if (slen > LRW'(NP)) begin
            slen = LRW'(NP);
        end
        rlen = (r_replace_len > LRW'(NP)) ? LRW'(NP) : r_replace_len;
    end

    assign o_cfg.search_pattern  = r_search_pattern[PW-1:0];
    assign o_cfg.search_len      = CW'(slen);
    assign o_cfg.replace_pattern = r_replace_pattern[PW-1:0];
    assign o_cfg.replace_len     = CW'(rlen);
    assign o_cfg.buffer_length   = r_buffer_length;

endmodule

// ----- rtl/sfr_core.sv -----
module sfr_core #(
    parameter int MAX_LENGTH_BITS = sfr_pkg::MAX_LENGTH_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfr_pkg::t_cfg    i_cfg,
    sfr_in_if.sink           i_in,
    output sfr_pkg::t_burst  o_burst,
    output logic             o_burst_valid,
    input  logic             i_burst_ready
);

    localparam int NP = sfr_pkg::MAX_PATTERN;
    localparam int CW = sfr_pkg::CNT_W;
    localparam int PW = sfr_pkg::LANES_W;
    localparam int TW = sfr_pkg::TOTAL_W;
    localparam int LW = (MAX_LENGTH_BITS < sfr_pkg::BUF_W) ? MAX_LENGTH_BITS : sfr_pkg::BUF_W;

    // input register
    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_eos;

    // match state
    logic [PW-1:0] r_held;
    logic [CW-1:0] r_held_cnt;
    logic [LW-1:0] r_emitted;
    logic [TW-1:0] r_total;

    logic [PW-1:0] n_held;
    logic [CW-1:0] n_held_cnt;
    logic [LW-1:0] n_emitted;
    logic [TW-1:0] n_total;

    logic                    adv;
    logic [NP-1:0]           held_eq;
    logic                    flush;
    logic [CW-1:0]           base_cnt;
    logic [CW-1:0]           w_cnt;
    logic [PW-1:0]           w_bytes;
    logic [NP-1:0][NP-1:0]   eq;
    logic                    whole;
    logic                    full;
    logic [NP:1]             suf_ok;
    logic [CW-1:0]           k_sel;
    logic [LW-1:0]           blen;
    logic [LW-1:0]           limit;
    logic [LW-1:0]           avail;
    logic [LW-1:0]           avail2;
    logic [CW-1:0]           a_cnt;
    logic [CW-1:0]           a_out;
    logic [CW-1:0]           b_cnt;
    logic [CW-1:0]           b_out;
    logic [PW-1:0]           b_bytes;

    assign adv         = r_in_valid && i_burst_ready;
    assign i_in.ready  = !r_in_valid || i_burst_ready;

    always_comb begin
        // held bytes still a proper prefix of the (possibly new) pattern?
        for (int j = 0; j < NP; j++) begin
            held_eq[j] = (r_held[8*j +: 8] == i_cfg.search_pattern[8*j +: 8])
                         || (CW'(j) >= r_held_cnt);
        end
        flush    = (r_held_cnt >= i_cfg.search_len) || !(&held_eq);
        base_cnt = flush ? '0 : r_held_cnt;

        for (int j = 0; j < NP; j++) begin
            if (CW'(j) < base_cnt) begin
                w_bytes[8*j +: 8] = r_held[8*j +: 8];
            end else if (CW'(j) == base_cnt) begin
                w_bytes[8*j +: 8] = r_in_byte;
            end else begin
                w_bytes[8*j +: 8] = 8'h00;
            end
        end
        w_cnt = base_cnt + CW'(1);

        for (int a = 0; a < NP; a++) begin
            for (int b = 0; b < NP; b++) begin
                eq[a][b] = (w_bytes[8*a +: 8] == i_cfg.search_pattern[8*b +: 8]);
            end
        end

        whole = 1'b1;
        for (int j = 0; j < NP; j++) begin
            if ((CW'(j) < w_cnt) && !eq[j][j]) begin
                whole = 1'b0;
            end
        end
        full = whole && (w_cnt == i_cfg.search_len);

        // suffix starting at lane k still a prefix of the pattern
        for (int k = 1; k <= NP; k++) begin
            suf_ok[k] = 1'b1;
            for (int j = 0; j < NP; j++) begin
                if (k + j < NP) begin
                    if ((CW'(k + j) < w_cnt) && !eq[k + j][j]) begin
                        suf_ok[k] = 1'b0;
                    end
                end
            end
        end
        k_sel = w_cnt;
        for (int k = NP; k >= 1; k--) begin
            if (suf_ok[k] && (CW'(k) <= w_cnt)) begin
                k_sel = CW'(k);
            end
        end

        // output budget
        blen   = i_cfg.buffer_length[LW-1:0];
        limit  = (blen == '0) ? '0 : blen - LW'(1);
        avail  = (limit > r_emitted) ? limit - r_emitted : '0;
        a_cnt  = (flush || r_in_eos) ? r_held_cnt : '0;
        a_out  = (avail < LW'(a_cnt)) ? avail[CW-1:0] : a_cnt;
        avail2 = avail - LW'(a_out);

        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_emitted  = r_emitted;
        n_total    = r_total;
        b_cnt      = '0;
        b_bytes    = w_bytes;

        priority if (r_in_eos) begin
            n_held_cnt = '0;
            n_total    = '0;
        end else if (full) begin
            n_held_cnt = '0;
            if (avail2 != '0) begin
                b_bytes = i_cfg.replace_pattern;
                b_cnt   = i_cfg.replace_len;
                if (r_total != sfr_pkg::COUNT_SAT) begin
                    n_total = r_total + TW'(1);
                end
            end
        end else if (whole) begin
            n_held     = w_bytes;
            n_held_cnt = w_cnt;
        end else begin
            n_held     = w_bytes >> {k_sel, 3'b000};
            n_held_cnt = w_cnt - k_sel;
            b_cnt      = k_sel;
        end

        b_out = (avail2 < LW'(b_cnt)) ? avail2[CW-1:0] : b_cnt;
        n_emitted = r_in_eos ? '0 : r_emitted + LW'(a_out) + LW'(b_out);
    end

    assign o_burst_valid   = r_in_valid;
    assign o_burst.a_bytes = r_held;
    assign o_burst.a_cnt   = a_out;
    assign o_burst.b_bytes = b_bytes;
    assign o_burst.b_cnt   = r_in_eos ? '0 : b_out;
    assign o_burst.mark    = r_in_eos;
    assign o_burst.total   = r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_held_cnt <= '0;
            r_emitted  <= '0;
            r_total    <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_held_cnt <= n_held_cnt;
                r_emitted  <= n_emitted;
                r_total    <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_eos  <= i_in.end_of_string;
        end
        if (adv) begin
            r_held <= n_held;
        end
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt < CW'(NP))
        else $error("held count reached pattern size");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_eos) |=> (r_held_cnt == '0 && r_emitted == '0 && r_total == '0))
        else $error("state not cleared after end of string");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_in_eos) |=> (r_total >= $past(r_total)))
        else $error("replacement count went down within a string");

endmodule

// ----- rtl/sfr_ser.sv -----
module sfr_ser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfr_pkg::t_burst  i_burst,
    input  logic             i_burst_valid,
    output logic             o_burst_ready,
    sfr_out_if.source        o_out
);

    localparam int NP = sfr_pkg::MAX_PATTERN;
    localparam int CW = sfr_pkg::CNT_W;
    localparam int PW = sfr_pkg::LANES_W;
    localparam int TW = sfr_pkg::TOTAL_W;

    logic [PW-1:0] r_a;
    logic [CW-1:0] r_a_cnt;
    logic [PW-1:0] r_b;
    logic [CW-1:0] r_b_cnt;
    logic          r_mark;
    logic [TW-1:0] r_total;

    logic has_byte;
    logic out_valid;
    logic take;
    logic last_one;
    logic load;

    assign has_byte  = (r_a_cnt != '0) || (r_b_cnt != '0);
    assign out_valid = has_byte || r_mark;
    assign take      = out_valid && o_out.ready;
    assign last_one  = r_mark ? !has_byte
                     : (((r_a_cnt == CW'(1)) && (r_b_cnt == '0)) ||
                        ((r_a_cnt == '0) && (r_b_cnt == CW'(1))));
    assign o_burst_ready = !out_valid || (take && last_one);
    assign load          = i_burst_valid && o_burst_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_cnt <= '0;
            r_b_cnt <= '0;
            r_mark  <= 1'b0;
        end else if (load) begin
            r_a_cnt <= i_burst.a_cnt;
            r_b_cnt <= i_burst.b_cnt;
            r_mark  <= i_burst.mark;
        end else if (take) begin
            priority if (r_a_cnt != '0) begin
                r_a_cnt <= r_a_cnt - CW'(1);
            end else if (r_b_cnt != '0) begin
                r_b_cnt <= r_b_cnt - CW'(1);
            end else begin
                r_mark <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a     <= i_burst.a_bytes;
            r_b     <= i_burst.b_bytes;
            r_total <= i_burst.total;
        end else if (take) begin
            if (r_a_cnt != '0) begin
                r_a <= {8'h00, r_a[PW-1:8]};
            end else if (r_b_cnt != '0) begin
                r_b <= {8'h00, r_b[PW-1:8]};
            end
        end
    end

    assign o_out.valid         = out_valid;
    assign o_out.out_byte      = (r_a_cnt != '0) ? r_a[7:0]
                               : (r_b_cnt != '0) ? r_b[7:0] : 8'h00;
    assign o_out.byte_valid    = has_byte;
    assign o_out.last          = !has_byte;
    assign o_out.replace_count = has_byte ? '0 : r_total;

    a_mark_after_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !load && has_byte) |=> (r_mark == $past(r_mark)))
        else $error("end marker dropped before its bytes");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_cnt < CW'(NP)) && (r_b_cnt <= CW'(NP)))
        else $error("item count out of range");

endmodule

// ----- rtl/stream_find_replace_unit.sv -----
// Latency: an item's first result is offered after the item passes the input register, then
// the result register.
// Throughput: one item per cycle while each item yields at most one result and the output
// is ready; more results hold off the input until the one-per-cycle port takes the last.
// Reset: synchronous, active low; restores CR LF -> space mode and clears all match state.
module stream_find_replace_unit #(
    parameter int MAX_LENGTH_BITS = sfr_pkg::MAX_LENGTH_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sfr_in_if.sink                          i_in,
    sfr_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    sfr_pkg::t_cfg   cfg;
    sfr_pkg::t_burst burst;
    logic            burst_valid;
    logic            burst_ready;

    sfr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sfr_core #(
        .MAX_LENGTH_BITS (MAX_LENGTH_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in          (i_in),
        .o_burst       (burst),
        .o_burst_valid (burst_valid),
        .i_burst_ready (burst_ready)
    );

    sfr_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst       (burst),
        .i_burst_valid (burst_valid),
        .o_burst_ready (burst_ready),
        .o_out         (o_out)
    );

endmodule

// ----- test/tb.sv -----
module tb;

    localparam int TW  = sfr_pkg::TOTAL_W;
    localparam int LRW = sfr_pkg::LEN_REG_W;
    localparam int BW  = sfr_pkg::BUF_W;
    localparam int NP  = sfr_pkg::MAX_PATTERN;

    typedef struct packed {
        logic [7:0]    out_byte;
        logic          byte_valid;
        logic          last;
        logic [TW-1:0] replace_count;
    } t_result;

    typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    localparam int CYCLE_LIMIT = 200000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_addr;
    logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    sfr_in_if  in_ch();
    sfr_out_if out_ch();

    stream_find_replace_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // predictor copy of the registers and the match state
    logic [63:0]    cfg_search_pattern  = sfr_pkg::RST_SEARCH_PATTERN;
    logic [LRW-1:0] cfg_search_len      = sfr_pkg::RST_SEARCH_LENGTH;
    logic [63:0]    cfg_replace_pattern = sfr_pkg::RST_REPLACE_PATTERN;
    logic [LRW-1:0] cfg_replace_len     = sfr_pkg::RST_REPLACE_LENGTH;
    logic [BW-1:0]  cfg_buffer_len      = sfr_pkg::RST_BUFFER_LENGTH;

    logic [63:0]   held_bytes  = '0;
    int            held_n      = 0;
    int            emitted_n   = 0;
    logic [TW-1:0] match_total = '0;

    t_result rewrite_q[$];
    t_result head;

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int strings_done  = 0;
    int counted_total = 0;
    int cycles        = 0;
    int burst_left    = 0;

    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;

    always #4 i_clk = ~i_clk;

    function automatic int out_limit();
        return (cfg_buffer_len == 0) ? 0 : int'(cfg_buffer_len) - 1;
    endfunction

    function automatic bit held_matches(int n);
        logic [63:0] mask;
        mask = (n >= 8) ? '1 : (64'd1 << (8 * n)) - 64'd1;
        return ((held_bytes ^ cfg_search_pattern) & mask) == '0;
    endfunction

    function automatic void push_result(logic [7:0] b, logic v, logic l,
                                        logic [TW-1:0] c);
        t_result r;
        r.out_byte      = b;
        r.byte_valid    = v;
        r.last          = l;
        r.replace_count = c;
        rewrite_q.push_back(r);
    endfunction

    function automatic void emit_char(logic [7:0] b);
        if (emitted_n < out_limit()) begin
            push_result(b, 1'b1, 1'b0, '0);
            emitted_n++;
        end
    endfunction

    function automatic void flush_held();
        int c;
        c = (held_n > 8) ? 8 : held_n;
        for (int i = 0; i < c; i++)
            emit_char(held_bytes[8*i +: 8]);
        held_bytes = '0;
        held_n     = 0;
    endfunction

    function automatic int search_len_eff();
        if (cfg_search_len == 0)
            return 1;
        return (cfg_search_len > NP) ? NP : int'(cfg_search_len);
    endfunction

    function automatic void predict_rewrite(logic [7:0] b, logic eos);
        int slen;
        int rlen;
        int m;
        slen = search_len_eff();
        if (held_n >= slen || held_n > 7 || !held_matches(held_n))
            flush_held();
        if (eos) begin
            flush_held();
            push_result(8'h00, 1'b0, 1'b1, match_total);
            emitted_n   = 0;
            match_total = '0;
            return;
        end
        held_bytes |= 64'(b) << (8 * held_n);
        held_n++;
        while (held_n > 0) begin
            m = (held_n < slen) ? held_n : slen;
            if (held_matches(m)) begin
                if (m != slen)
                    break;
                if (emitted_n < out_limit()) begin
                    rlen = (cfg_replace_len > NP) ? NP : int'(cfg_replace_len);
                    if (match_total != sfr_pkg::COUNT_SAT)
                        match_total++;
                    for (int i = 0; i < rlen; i++)
                        emit_char(cfg_replace_pattern[8*i +: 8]);
                end
                held_bytes = (slen >= 8) ? '0 : (held_bytes >> (8 * slen));
                held_n -= slen;
            end else begin
                emit_char(held_bytes[7:0]);
                held_bytes >>= 8;
                held_n--;
            end
        end
    endfunction

    function automatic void check_field(string name, logic [TW-1:0] want,
                                        logic [TW-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // result side: compare each accepted item with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (rewrite_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, got %h/%b/%b/%h",
                         $time, out_ch.out_byte, out_ch.byte_valid, out_ch.last,
                         out_ch.replace_count);
            end else begin
                head = rewrite_q.pop_front();
                check_field("out_byte", TW'(head.out_byte), TW'(out_ch.out_byte));
                check_field("byte_valid", TW'(head.byte_valid), TW'(out_ch.byte_valid));
                check_field("last", TW'(head.last), TW'(out_ch.last));
                check_field("replace_count", head.replace_count, out_ch.replace_count);
                if (head.last)
                    counted_total += int'(head.replace_count);
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 160);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:     out_ch.ready <= 1'b1;
            RX_RANDOM:   out_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: out_ch.ready <= (rx_left % 5 != 0);
            default:     out_ch.ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d items still expected",
                     cycles, rewrite_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] b, input logic eos);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.end_of_string <= eos;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        predict_rewrite(b, eos);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic end_string();
        send_char(8'($urandom), 1'b1);
        strings_done++;
    endtask

    // drain all predicted items, then give the pipeline time to empty
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (rewrite_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input sfr_pkg::t_cfg_reg r, input logic [63:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= r;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (r)
            sfr_pkg::REG_SEARCH_PATTERN:  cfg_search_pattern  = v;
            sfr_pkg::REG_SEARCH_LENGTH:   cfg_search_len      = v[LRW-1:0];
            sfr_pkg::REG_REPLACE_PATTERN: cfg_replace_pattern = v;
            sfr_pkg::REG_REPLACE_LENGTH:  cfg_replace_len     = v[LRW-1:0];
            sfr_pkg::REG_BUFFER_LENGTH:   cfg_buffer_len      = v[BW-1:0];
            default: ;
        endcase
    endtask

    task automatic program_config(input logic [63:0] sp, input logic [63:0] sl,
                                  input logic [63:0] rp, input logic [63:0] rl,
                                  input logic [63:0] bl);
        settle();
        write_reg(sfr_pkg::REG_SEARCH_PATTERN, sp);
        write_reg(sfr_pkg::REG_SEARCH_LENGTH, sl);
        write_reg(sfr_pkg::REG_REPLACE_PATTERN, rp);
        write_reg(sfr_pkg::REG_REPLACE_LENGTH, rl);
        write_reg(sfr_pkg::REG_BUFFER_LENGTH, bl);
    endtask

    // reset mode: CR LF becomes one space, a lone CR passes
    task automatic test_crlf_default();
        send_char(8'h61, 1'b0);
        send_char(sfr_pkg::CHAR_CR, 1'b0);
        send_char(sfr_pkg::CHAR_LF, 1'b0);
        send_char(sfr_pkg::CHAR_CR, 1'b0);
        send_char(sfr_pkg::CHAR_CR, 1'b0);
        send_char(sfr_pkg::CHAR_LF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(sfr_pkg::CHAR_CR, 1'b0);
        end_string();
    endtask

    task automatic test_length_extremes();
        // search length 0 acts as 1, replace length 15 acts as 8
        program_config(64'h78, 0, 64'hffee_ddcc_bbaa_9988, 15, 16'hffff);
        send_text("xyx");
        end_string();
        // search length 15 acts as 8, empty replacement deletes the match
        program_config(64'h6161_6161_6161_6161, 15, 64'h0, 0, 16'hffff);
        send_text("aaaaaaaab");
        end_string();
    endtask

    task automatic test_output_limit();
        // limit 2: replacement truncated, later match not counted
        program_config(64'h61, 1, 64'h52_5150, 3, 3);
        send_text("baa");
        end_string();
        // zero buffer: only the end marker comes out
        program_config(64'h61, 1, 64'h52_5150, 3, 0);
        send_text("ba");
        end_string();
    endtask

    task automatic test_midstring_change();
        program_config(64'h63_6261, 3, 64'h5a, 1, 16'hffff);
        send_text("xab");
        settle();
        // held "ab" is no longer a prefix and goes out unmatched
        write_reg(sfr_pkg::REG_SEARCH_PATTERN, 64'h63_5861);
        send_text("bc");
        end_string();
    endtask

    // back-to-back matches that produce no output at all
    task automatic test_match_run();
        program_config(64'h7a, 1, 64'h0, 0, 16'hffff);
        repeat (12) send_char(8'h7a, 1'b0);
        end_string();
    endtask

    task automatic test_random_text();
        logic [7:0]  alpha[2];
        logic [63:0] sp;
        logic [63:0] bl;
        int          start;
        int          slen;
        int          len;
        int          sel;
        start = items_sent;
        while (items_sent - start < 100) begin
            if ($urandom_range(0, 3) == 0) begin
                alpha[0] = sfr_pkg::CHAR_CR;
                alpha[1] = sfr_pkg::CHAR_LF;
            end else begin
                alpha[0] = 8'($urandom);
                alpha[1] = 8'($urandom);
            end
            for (int i = 0; i < 8; i++)
                sp[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : alpha[$urandom_range(0, 1)];
            case ($urandom_range(0, 5))
                0:       bl = $urandom_range(0, 2);
                1:       bl = $urandom_range(3, 30);
                2:       bl = $urandom_range(0, 65535);
                default: bl = 65535;
            endcase
            program_config(sp,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4),
                {$urandom, $urandom},
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3),
                bl);
            slen = search_len_eff();
            repeat ($urandom_range(1, 4)) begin
                len = $urandom_range(0, 20);
                for (int k = 0; k < len; k++) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 3)
                        send_char(8'($urandom), 1'b0);
                    else if (sel < 5)
                        for (int j = 0; j < slen; j++)
                            send_char(sp[8*j +: 8], 1'b0);
                    else
                        send_char(alpha[$urandom_range(0, 1)], 1'b0);
                end
                // an unterminated string carries held bytes into the next setting
                if ($urandom_range(0, 3) != 0)
                    end_string();
            end
        end
        end_string();
    endtask

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_addr          = '0;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = '0;
        in_ch.end_of_string = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_crlf_default();
        test_length_extremes();
        test_output_limit();
        test_midstring_change();
        test_match_run();
        test_random_text();
        settle();

        $display("Sent %0d input items in %0d strings, checked %0d result items.",
                 items_sent, strings_done, results_seen);
        $display("Ran CR LF mode, clamped lengths, buffer limits, a pattern swap and %s",
                 "random text with stalls on both sides.");
        $display("Replacements reported on end markers: %0d.", counted_total);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
